// ===== design/q2e_pkg.sv =====
package q2e_pkg;

	// Default sizes
	localparam int QUAT_W_DEF  = 16;
	localparam int ANGLE_W_DEF = 16;
	localparam int STEPS_DEF   = 16;

	// Internal Q.28 word and CORDIC widths
	localparam int DW = 36;
	localparam int CW = DW + 2;
	localparam int ZW = 35;

	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q28     = 64'sd268435456;

	// Square root runs one result bit per stage over a Q.56 radicand
	localparam int SQ_STEPS = 29;
	localparam int SQ_W     = 58;

	typedef struct packed {
		logic signed [DW-1:0] sr;
		logic signed [DW-1:0] cr;
		logic signed [DW-1:0] sy;
		logic signed [DW-1:0] cy;
		logic signed [DW-1:0] sp;
	} item_t;

	// atan(2^-i) in Q.30
	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] r;
		unique case (i)
			0:  r = 35'sd843314857;
			1:  r = 35'sd497837829;
			2:  r = 35'sd263043837;
			3:  r = 35'sd133525159;
			4:  r = 35'sd67021687;
			5:  r = 35'sd33543516;
			6:  r = 35'sd16775851;
			7:  r = 35'sd8388437;
			8:  r = 35'sd4194283;
			9:  r = 35'sd2097149;
			10: r = 35'sd1048576;
			11: r = 35'sd524288;
			12: r = 35'sd262144;
			13: r = 35'sd131072;
			14: r = 35'sd65536;
			15: r = 35'sd32768;
			16: r = 35'sd16384;
			17: r = 35'sd8192;
			18: r = 35'sd4096;
			19: r = 35'sd2048;
			20: r = 35'sd1024;
			21: r = 35'sd512;
			22: r = 35'sd256;
			23: r = 35'sd128;
			24: r = 35'sd64;
			25: r = 35'sd32;
			26: r = 35'sd16;
			27: r = 35'sd8;
			28: r = 35'sd4;
			29: r = 35'sd2;
			30: r = 35'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/q2e_front.sv =====
module q2e_front
	import q2e_pkg::*;
#(
	parameter int QUAT_WIDTH = QUAT_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic signed [QUAT_WIDTH-1:0] quat_w,
	input  logic signed [QUAT_WIDTH-1:0] quat_x,
	input  logic signed [QUAT_WIDTH-1:0] quat_y,
	input  logic signed [QUAT_WIDTH-1:0] quat_z,
	output logic                         push,
	output item_t                        item
);

	localparam int PF  = 2 * (QUAT_WIDTH - 2);
	localparam int SHR = (PF >= 28) ? PF - 28 : 0;
	localparam int SHL = (PF >= 28) ? 0 : 28 - PF;

	function automatic logic signed [DW-1:0] mul28(input logic signed [QUAT_WIDTH-1:0] a,
		input logic signed [QUAT_WIDTH-1:0] b);
		logic signed [2*QUAT_WIDTH-1:0] p;
		logic signed [63:0]             pe;
		p  = a * b;
		pe = 64'(p);
		pe = (pe >>> SHR) <<< SHL;
		return pe[DW-1:0];
	endfunction

	logic                 valid_s1, valid_s2;
	logic signed [DW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;
	item_t                item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		wx_s1 <= mul28(quat_w, quat_x);
		yz_s1 <= mul28(quat_y, quat_z);
		xx_s1 <= mul28(quat_x, quat_x);
		yy_s1 <= mul28(quat_y, quat_y);
		wz_s1 <= mul28(quat_w, quat_z);
		xy_s1 <= mul28(quat_x, quat_y);
		zz_s1 <= mul28(quat_z, quat_z);
		wy_s1 <= mul28(quat_w, quat_y);
		zx_s1 <= mul28(quat_z, quat_x);
		item_s2.sr <= (wx_s1 + yz_s1) <<< 1;
		item_s2.cr <= DW'(ONE_Q28) - ((xx_s1 + yy_s1) <<< 1);
		item_s2.sy <= (wz_s1 + xy_s1) <<< 1;
		item_s2.cy <= DW'(ONE_Q28) - ((yy_s1 + zz_s1) <<< 1);
		item_s2.sp <= (wy_s1 - zx_s1) <<< 1;
	end

	assign push = valid_s2;
	assign item = item_s2;

endmodule

// ===== design/q2e_fifo.sv =====
module q2e_fifo
	import q2e_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	input  logic  pop,
	output item_t rdata,
	output logic  empty,
	output logic  full
);

	item_t       mem_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign rdata = mem_q[rd_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue underflow");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) == (wr_q != rd_q))
		else $error("queue pointers out of step");
`endif

endmodule

// ===== design/q2e_cordic.sv =====
module q2e_cordic
	import q2e_pkg::*;
#(
	parameter int STEPS = STEPS_DEF,
	parameter int AW    = ANGLE_W_DEF,
	parameter int OUT_W = ANGLE_W_DEF,
	parameter bit HALF  = 1'b0
) (
	input  logic                    clk,
	input  logic signed [DW-1:0]    a,
	input  logic signed [DW-1:0]    b,
	output logic signed [OUT_W-1:0] angle
);

	localparam int     SH    = 33 - AW;
	localparam longint LIM   = ((HALF ? HALF_PI_Q30 : PI_Q30) + (64'sd1 <<< (SH - 1))) >>> SH;
	localparam logic signed [ZW:0] LIM_W = (ZW + 1)'(LIM);

	logic signed [CW-1:0] x_s [0:STEPS];
	logic signed [CW-1:0] y_s [0:STEPS];
	logic signed [ZW-1:0] z_s [0:STEPS];
	logic                 zero_s [0:STEPS];
	logic signed [OUT_W-1:0] angle_q;

	// a == 0 takes the axis answer directly and freezes the angle
	always_ff @(posedge clk) begin
		zero_s[0] <= (a == '0);
		if (a == '0) begin
			x_s[0] <= CW'(b);
			y_s[0] <= '0;
			z_s[0] <= b[DW-1] ? ZW'(PI_Q30) : '0;
		end else if (b[DW-1]) begin
			x_s[0] <= -CW'(b);
			y_s[0] <= -CW'(a);
			z_s[0] <= a[DW-1] ? -ZW'(PI_Q30) : ZW'(PI_Q30);
		end else begin
			x_s[0] <= CW'(b);
			y_s[0] <= CW'(a);
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [ZW-1:0] TAB = atan_q30(i);
		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
			if (zero_s[i]) begin
				x_s[i+1] <= x_s[i];
				y_s[i+1] <= y_s[i];
				z_s[i+1] <= z_s[i];
			end else if (!y_s[i][CW-1]) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + TAB;
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - TAB;
			end
		end
	end

	logic signed [ZW:0] rnd;
	always_comb begin
		rnd = ((ZW + 1)'(z_s[STEPS]) + ((ZW + 1)'(1) <<< (SH - 1))) >>> SH;
	end

	always_ff @(posedge clk) begin
		if (rnd > LIM_W)
			angle_q <= LIM_W[OUT_W-1:0];
		else if (rnd < -LIM_W)
			angle_q <= OUT_W'(-LIM_W);
		else
			angle_q <= rnd[OUT_W-1:0];
	end

	assign angle = angle_q;

endmodule

// ===== design/q2e_back.sv =====
module q2e_back
	import q2e_pkg::*;
#(
	parameter int ANGLE_WIDTH  = ANGLE_W_DEF,
	parameter int ARCTAN_STEPS = STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  item_t                         item,
	output logic                          done,
	output logic signed [ANGLE_WIDTH-1:0] roll_angle,
	output logic signed [ANGLE_WIDTH-2:0] pitch_angle,
	output logic signed [ANGLE_WIDTH-1:0] yaw_angle,
	output logic                          pitch_clamped
);

	localparam int     SH   = 33 - ANGLE_WIDTH;
	localparam longint HPI  = (HALF_PI_Q30 + (64'sd1 <<< (SH - 1))) >>> SH;
	localparam int     CL   = ARCTAN_STEPS + 2;
	localparam int     LAT  = 1 + SQ_STEPS + CL + 1;
	localparam logic [SQ_W-1:0] RAD_ONE = SQ_W'(1) << 56;

	logic [LAT-1:0] valid_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s <= '0;
		else
			valid_s <= {valid_s[LAT-2:0], in_valid};
	end

	// Square of sp, skipped when the arcsine saturates
	logic              in_range;
	logic signed [28:0] sp29;
	logic signed [SQ_W-1:0] sq_full;
	logic [SQ_W-1:0]   sq_s1;

	always_comb begin
		in_range = (item.sp < DW'(ONE_Q28)) && (item.sp > -DW'(ONE_Q28));
		sp29     = item.sp[28:0];
		sq_full  = sp29 * sp29;
	end

	logic signed [DW-1:0] sr_d [0:SQ_STEPS];
	logic signed [DW-1:0] cr_d [0:SQ_STEPS];
	logic signed [DW-1:0] sy_d [0:SQ_STEPS];
	logic signed [DW-1:0] cy_d [0:SQ_STEPS];
	logic signed [DW-1:0] sp_d [0:SQ_STEPS];
	logic                 clamp_d [0:SQ_STEPS];

	always_ff @(posedge clk) begin
		sq_s1      <= in_range ? SQ_W'(sq_full) : '0;
		sr_d[0]    <= item.sr;
		cr_d[0]    <= item.cr;
		sy_d[0]    <= item.sy;
		cy_d[0]    <= item.cy;
		sp_d[0]    <= item.sp;
		clamp_d[0] <= !in_range;
		for (int k = 0; k < SQ_STEPS; k++) begin
			sr_d[k+1]    <= sr_d[k];
			cr_d[k+1]    <= cr_d[k];
			sy_d[k+1]    <= sy_d[k];
			cy_d[k+1]    <= cy_d[k];
			sp_d[k+1]    <= sp_d[k];
			clamp_d[k+1] <= clamp_d[k];
		end
	end

	// Floor square root, one result bit per stage
	logic [SQ_W-1:0] v_s   [0:SQ_STEPS];
	logic [SQ_W-1:0] res_s [0:SQ_STEPS];

	assign v_s[0]   = RAD_ONE - sq_s1;
	assign res_s[0] = '0;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (56 - 2 * k);
		logic [SQ_W-1:0] trial;
		assign trial = res_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (v_s[k] >= trial) begin
				v_s[k+1]   <= v_s[k] - trial;
				res_s[k+1] <= (res_s[k] >> 1) + BIT;
			end else begin
				v_s[k+1]   <= v_s[k];
				res_s[k+1] <= res_s[k] >> 1;
			end
		end
	end

	logic signed [DW-1:0] cp;
	assign cp = DW'(res_s[SQ_STEPS]);

	logic signed [ANGLE_WIDTH-1:0] roll_c, yaw_c;
	logic signed [ANGLE_WIDTH-2:0] pitch_c;

	q2e_cordic #(.STEPS(ARCTAN_STEPS), .AW(ANGLE_WIDTH), .OUT_W(ANGLE_WIDTH), .HALF(1'b0))
	u_roll (.clk(clk), .a(sr_d[SQ_STEPS]), .b(cr_d[SQ_STEPS]), .angle(roll_c));

	q2e_cordic #(.STEPS(ARCTAN_STEPS), .AW(ANGLE_WIDTH), .OUT_W(ANGLE_WIDTH), .HALF(1'b0))
	u_yaw (.clk(clk), .a(sy_d[SQ_STEPS]), .b(cy_d[SQ_STEPS]), .angle(yaw_c));

	q2e_cordic #(.STEPS(ARCTAN_STEPS), .AW(ANGLE_WIDTH), .OUT_W(ANGLE_WIDTH - 1), .HALF(1'b1))
	u_pitch (.clk(clk), .a(sp_d[SQ_STEPS]), .b(cp), .angle(pitch_c));

	// Saturation flag and sign ride alongside the CORDIC stages
	logic [CL-1:0] clamp_c, neg_c;

	always_ff @(posedge clk) begin
		clamp_c <= {clamp_c[CL-2:0], clamp_d[SQ_STEPS]};
		neg_c   <= {neg_c[CL-2:0], sp_d[SQ_STEPS][DW-1]};
	end

	logic signed [ANGLE_WIDTH-1:0] roll_q, yaw_q;
	logic signed [ANGLE_WIDTH-2:0] pitch_q;
	logic                          clamped_q;

	always_ff @(posedge clk) begin
		roll_q    <= roll_c;
		yaw_q     <= yaw_c;
		clamped_q <= clamp_c[CL-1];
		if (clamp_c[CL-1])
			pitch_q <= neg_c[CL-1] ? -(ANGLE_WIDTH - 1)'(HPI) : (ANGLE_WIDTH - 1)'(HPI);
		else
			pitch_q <= pitch_c;
	end

	assign done          = valid_s[LAT-1];
	assign roll_angle    = roll_q;
	assign pitch_angle   = pitch_q;
	assign yaw_angle     = yaw_q;
	assign pitch_clamped = clamped_q;

`ifndef NO_ASSERTIONS
	a_clamp_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(done && pitch_clamped) |-> (pitch_angle != '0))
		else $error("saturated pitch is zero");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s[LAT-2]))
		else $error("beat out of step");
	a_pitch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pitch_angle <= (ANGLE_WIDTH - 1)'(HPI) &&
			pitch_angle >= -(ANGLE_WIDTH - 1)'(HPI)))
		else $error("pitch out of range");
`endif

endmodule

// ===== design/quaternion_to_euler.sv =====
// Quaternion (Q1.14) to ZYX Euler angles (roll and yaw Q2.13, pitch Q1.13).
// The pitch path runs a 29-stage square root ahead of its CORDIC; each CORDIC
// iterates ARCTAN_STEPS stages.
// Throughput: one beat per cycle while busy is low; busy is low in steady state.
// The receiver cannot stall: each result shows for one cycle with done.
// arst_n clears valid and queue state; datapath registers are not reset.
module quaternion_to_euler
	import q2e_pkg::*;
#(
	parameter int QUAT_WIDTH   = QUAT_W_DEF,
	parameter int ANGLE_WIDTH  = ANGLE_W_DEF,
	parameter int ARCTAN_STEPS = STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [QUAT_WIDTH-1:0]  quat_w,
	input  logic signed [QUAT_WIDTH-1:0]  quat_x,
	input  logic signed [QUAT_WIDTH-1:0]  quat_y,
	input  logic signed [QUAT_WIDTH-1:0]  quat_z,
	output logic                          done,
	output logic signed [ANGLE_WIDTH-1:0] roll_angle,
	output logic signed [ANGLE_WIDTH-2:0] pitch_angle,
	output logic signed [ANGLE_WIDTH-1:0] yaw_angle,
	output logic                          pitch_clamped
);

	logic  push, empty, full;
	item_t f_item, q_item;

	q2e_front #(.QUAT_WIDTH(QUAT_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .take(start && !busy),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.push(push), .item(f_item)
	);

	q2e_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(f_item),
		.pop(!empty), .rdata(q_item), .empty(empty), .full(full)
	);

	q2e_back #(.ANGLE_WIDTH(ANGLE_WIDTH), .ARCTAN_STEPS(ARCTAN_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(!empty), .item(q_item),
		.done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
	);

	assign busy = full;

endmodule
